@@ src/osdah_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and the tangent table of the artificial horizon block.
package osdah_pkg;

   localparam int TAN_W = 29;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 5;

   typedef logic signed [8:0] angle_type;
   typedef logic [CSR_IDX_W-1:0] csr_index_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;

   localparam csr_index_type CSR_ORIGIN_COLUMN = 2'd0;
   localparam csr_index_type CSR_ORIGIN_ROW = 2'd1;

   localparam logic [4:0] ORIGIN_COLUMN_RESET = 5'd9;
   localparam logic [3:0] ORIGIN_ROW_RESET = 4'd6;
   localparam logic [5:0] DRAWN_COLUMN_RESET = 6'd9;
   localparam logic [4:0] DRAWN_ROW_RESET = 5'd6;

   localparam logic [7:0] BLANK_GLYPH = 8'h20;
   localparam logic [7:0] GLYPH_BASE = 8'h05;

   // tan(89.99 deg) in unsigned Q13.16, used for exactly plus or minus ninety degrees
   localparam logic [TAN_W-1:0] TAN_NEAR_RIGHT = 29'd375493617;

   // floor(v / 18) = (v * DIV18_RECIP) >> DIV18_SHIFT for v below 32768
   localparam logic [11:0] DIV18_RECIP = 12'd3641;
   localparam int DIV18_SHIFT = 16;

   // round(tan(d) * 65536) for d = 0..89
   localparam logic [TAN_W-1:0] TAN_Q16 [90] = '{
      29'd0, 29'd1144, 29'd2289, 29'd3435, 29'd4583,
      29'd5734, 29'd6888, 29'd8047, 29'd9210, 29'd10380,
      29'd11556, 29'd12739, 29'd13930, 29'd15130, 29'd16340,
      29'd17560, 29'd18792, 29'd20036, 29'd21294, 29'd22566,
      29'd23853, 29'd25157, 29'd26478, 29'd27818, 29'd29179,
      29'd30560, 29'd31964, 29'd33392, 29'd34846, 29'd36327,
      29'd37837, 29'd39378, 29'd40951, 29'd42560, 29'd44205,
      29'd45889, 29'd47615, 29'd49385, 29'd51202, 29'd53070,
      29'd54991, 29'd56970, 29'd59009, 29'd61113, 29'd63287,
      29'd65536, 29'd67865, 29'd70279, 29'd72785, 29'd75391,
      29'd78103, 29'd80930, 29'd83882, 29'd86969, 29'd90203,
      29'd93595, 29'd97161, 29'd100917, 29'd104880, 29'd109070,
      29'd113512, 29'd118230, 29'd123255, 29'd128622, 29'd134369,
      29'd140542, 29'd147196, 29'd154393, 29'd162207, 29'd170727,
      29'd180059, 29'd190330, 29'd201699, 29'd214359, 29'd228551,
      29'd244584, 29'd262851, 29'd283868, 29'd308323, 29'd337153,
      29'd371673, 29'd413778, 29'd466313, 29'd533748, 29'd623533,
      29'd749080, 29'd937208, 29'd1250501, 29'd1876705, 29'd3754555
   };

   typedef struct packed {
      logic             neg;
      logic [TAN_W-1:0] mag;
   } tan_type;

   typedef struct packed {
      logic [5:0] col;
      logic [4:0] row;
   } cell_type;

   typedef struct packed {
      cell_type   loc;
      logic [7:0] glyph;
   } result_type;

   typedef struct packed {
      logic       busy;
      logic       emit;
      result_type res;
   } draw_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ERASE,
      ST_DRAW,
      ST_FLUSH
   } hor_state_type;

   // width of the signed drawing-column offset x = 12c - 6N + 6
   function automatic int x_width(int cols);
      return $clog2(6 * cols) + 1;
   endfunction

   // width of the signed Q0 base term nose + 9R - 1
   function automatic int base_width(int rows);
      return TAN_W + $clog2(9 * rows + 1) + 1 - 16 + 2;
   endfunction

   // reduce to -89..89 and look up; exactly +-90 uses the near-right value
   function automatic tan_type tangent(angle_type deg);
      logic signed [9:0] r;
      logic signed [9:0] a;
      tan_type t;
      r = {deg[8], deg};
      if (r > 10'sd89) begin
         r = r - 10'sd180;
      end else if (r < -10'sd89) begin
         r = r + 10'sd180;
      end
      a = r[9] ? -r : r;
      t.neg = r[9];
      t.mag = TAN_Q16[a[6:0]];
      if (deg == 9'sd90) begin
         t.neg = 1'b0;
         t.mag = TAN_NEAR_RIGHT;
      end else if (deg == -9'sd90) begin
         t.neg = 1'b1;
         t.mag = TAN_NEAR_RIGHT;
      end
      return t;
   endfunction

endpackage

@@ src/osdah_ifs.sv @@
`timescale 1ns / 1ps
// Request and response channel interfaces of the artificial horizon block.
interface osdah_req_if;
   logic                valid;
   logic                ready;
   osdah_pkg::angle_type pitch_deg;
   osdah_pkg::angle_type roll_deg;

   modport source (output valid, output pitch_deg, output roll_deg, input ready);
   modport sink (input valid, input pitch_deg, input roll_deg, output ready);
endinterface

interface osdah_rsp_if;
   logic       valid;
   logic       ready;
   logic [5:0] cell_column;
   logic [4:0] cell_row;
   logic [7:0] glyph_code;
   logic       last_write;

   modport source (output valid, output cell_column, output cell_row, output glyph_code,
                   output last_write, input ready);
   modport sink (input valid, input cell_column, input cell_row, input glyph_code,
                 input last_write, output ready);
endinterface

@@ src/osdah_hit_calc.sv @@
`timescale 1ns / 1ps
// Per-column horizon hit pipeline: multiply, truncate, band check, glyph select.
module osdah_hit_calc #(
   parameter int NUM_COLUMNS = 12,
   parameter int NUM_ROWS = 5,
   localparam int IDX_W = $clog2(NUM_COLUMNS),
   localparam int X_W = osdah_pkg::x_width(NUM_COLUMNS),
   localparam int BASE_W = osdah_pkg::base_width(NUM_ROWS)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  logic [IDX_W-1:0]                  in_idx,
   input  logic signed [X_W-1:0]             in_x,
   input  logic signed [osdah_pkg::TAN_W:0]  tr,
   input  logic signed [BASE_W-1:0]          base,
   input  logic [4:0]                        origin_col,
   input  logic [3:0]                        origin_row,
   output osdah_pkg::draw_type               draw
);
   import osdah_pkg::*;

   localparam int PROD_W = TAN_W + 1 + X_W;
   localparam int ACC_W = ((PROD_W > BASE_W + 16) ? PROD_W : BASE_W + 16) + 1;
   localparam int HIT_W = ACC_W - 16;
   localparam int BAND = 18 * NUM_ROWS;
   localparam int V_W = $clog2(BAND);
   localparam int QP_W = V_W + 12;
   localparam int Q_W = $clog2(NUM_ROWS + 1);

   logic                     v1_ff;
   logic [IDX_W-1:0]         idx1_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   logic                     v2_ff;
   logic                     band2_ff;
   logic [IDX_W-1:0]         idx2_ff;
   logic [V_W-1:0]           vv_ff;

   logic signed [ACC_W-1:0]  acc;
   logic signed [ACC_W-1:0]  acc_adj;
   logic signed [HIT_W-1:0]  hit;
   logic                     band;
   logic [QP_W-1:0]          qprod;
   logic [Q_W-1:0]           q;
   logic [V_W-1:0]           rem_full;
   logic [4:0]               rem;
   logic [3:0]               sub;

   assign prod_in = PROD_W'(tr) * PROD_W'(in_x);

   // truncate toward zero: bias negative sums by one less than one unit
   assign acc = ACC_W'(prod_ff) + (ACC_W'(base) <<< 16);
   assign acc_adj = acc + $signed({{(ACC_W-16){1'b0}}, {16{acc[ACC_W-1]}}});
   assign hit = acc_adj[ACC_W-1:16];
   assign band = !hit[HIT_W-1] && (hit != '0) && (hit < HIT_W'(BAND));

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         idx1_ff  <= in_idx;
         prod_ff  <= prod_in;
         idx2_ff  <= idx1_ff;
         band2_ff <= band;
         vv_ff    <= V_W'(hit - HIT_W'(1));
      end
   end

   // split hit - 1 into character row and sub-row
   assign qprod = QP_W'(vv_ff) * QP_W'(DIV18_RECIP);
   assign q = Q_W'(qprod >> DIV18_SHIFT);
   assign rem_full = vv_ff - V_W'(18) * V_W'(q);
   assign rem = rem_full[4:0];

   always_comb begin
      sub = rem[4:1];
      if (sub == 4'd0) begin
         sub = 4'd1;
      end
   end

   assign draw.busy = v1_ff || v2_ff;
   assign draw.emit = v2_ff && band2_ff;
   assign draw.res.loc.col = 6'(origin_col) + 6'(idx2_ff);
   assign draw.res.loc.row = 5'(origin_row) + 5'(NUM_ROWS - 1) - 5'(q);
   assign draw.res.glyph = GLYPH_BASE + 8'(sub);

endmodule

@@ src/osd_artificial_horizon_glyphs.sv @@
`timescale 1ns / 1ps
// Top level: artificial horizon drawn as a stream of character-cell writes.
//
// A sample is accepted only in the idle state, so a new sample waits until the current one is through.
// While the response side is ready, the erase pass makes one write per cycle from the drawn-cell
// memory's single read port, then one drawing column per cycle enters the two-stage hit pipeline;
// the pipeline drains and is seen empty, a flush step sends the final write, and the block
// returns to idle to accept.
// Reset is synchronous; remembered cells read as column 9, row 6 until written.
module osd_artificial_horizon_glyphs #(
   parameter int NUM_COLUMNS = 12,
   parameter int NUM_ROWS = 5
) (
   input  logic                     clock,
   input  logic                     reset,
   osdah_req_if.sink                req_chan,
   osdah_rsp_if.source              rsp_chan,
   input  logic                     csr_we,
   input  osdah_pkg::csr_index_type csr_index,
   input  osdah_pkg::csr_data_type  csr_wdata
);
   import osdah_pkg::*;

   localparam int IDX_W = $clog2(NUM_COLUMNS);
   localparam int CNT_W = $clog2(NUM_COLUMNS + 1);
   localparam int X_W = x_width(NUM_COLUMNS);
   localparam int K = 9 * NUM_ROWS;
   localparam int K_W = $clog2(K + 1);
   localparam int PP_W = TAN_W + K_W;
   localparam int NOSE_W = PP_W + 1 - 16;
   localparam int BASE_W = base_width(NUM_ROWS);
   localparam int X_FIRST = 6 - 6 * NUM_COLUMNS;

   // control
   hor_state_type state_ff, state_in;
   logic [4:0]    origin_col_ff;
   logic [3:0]    origin_row_ff;
   logic          req_acc;

   // angle capture and the free-running tangent / nose pipeline
   angle_type                pitch_ff;
   angle_type                roll_ff;
   tan_type                  tan_r;
   tan_type                  tan_p;
   logic signed [TAN_W:0]    tr_ff;
   logic signed [TAN_W:0]    tr_in;
   logic [PP_W-1:0]          pprod_ff;
   logic                     pneg_ff;
   logic [NOSE_W-1:0]        nose_mag;
   logic signed [BASE_W-1:0] nose_s;
   logic signed [BASE_W-1:0] base_ff;
   logic signed [BASE_W-1:0] base_in;

   // sequencing counters
   logic [IDX_W-1:0]     idx_ff;
   logic [IDX_W-1:0]     slot_ff;
   logic [CNT_W-1:0]     iss_ff;
   logic signed [X_W-1:0] x_ff;
   logic                 idx_last;
   logic                 iss_done;

   // drawn-cell memory with valid bits standing in for the reset contents
   cell_type         drawn_mem [NUM_COLUMNS];
   logic [NUM_COLUMNS-1:0] vld_ff;
   cell_type         mem_q_ff;
   logic             vld_q_ff;
   logic [IDX_W-1:0] rd_addr;
   logic             mem_wr;

   // hit pipeline
   draw_type draw;
   logic     iss_valid;

   // result path: holding register, then output register
   logic       push_v;
   result_type push_res;
   logic       flush;
   logic       out_free;
   logic       push_ok;
   logic       push;
   logic       hold_v_ff, hold_v_in;
   result_type hold_ff;
   logic       rsp_v_ff, rsp_v_in;
   result_type rsp_ff;
   logic       rsp_last_ff;
   logic       load_out;
   logic       load_last;

   assign req_acc = req_chan.valid && req_chan.ready;
   assign idx_last = (idx_ff == IDX_W'(NUM_COLUMNS - 1));
   assign iss_done = (iss_ff == CNT_W'(NUM_COLUMNS));

   // configuration registers; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_col_ff <= ORIGIN_COLUMN_RESET;
         origin_row_ff <= ORIGIN_ROW_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ORIGIN_COLUMN: origin_col_ff <= csr_wdata;
            CSR_ORIGIN_ROW:    origin_row_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // Hold the angles from acceptance. The tangent and nose terms pass through the
   // tr_ff, pprod_ff and base_ff registers and settle before drawing uses them.
   always_ff @(posedge clock) begin
      if (req_acc) begin
         pitch_ff <= req_chan.pitch_deg;
         roll_ff  <= req_chan.roll_deg;
      end
   end

   assign tan_r = tangent(roll_ff);
   assign tan_p = tangent(pitch_ff);
   assign tr_in = tan_r.neg ? -$signed({1'b0, tan_r.mag}) : $signed({1'b0, tan_r.mag});

   // pitch tangent is negated, so a negative tangent gives a positive nose
   assign nose_mag = NOSE_W'(({1'b0, pprod_ff} + (PP_W + 1)'(32768)) >> 16);
   assign nose_s = $signed({2'b00, nose_mag});
   assign base_in = (pneg_ff ? nose_s : -nose_s) + BASE_W'(K - 1);

   always_ff @(posedge clock) begin
      tr_ff    <= tr_in;
      pprod_ff <= PP_W'(tan_p.mag) * PP_W'(K);
      pneg_ff  <= tan_p.neg;
      base_ff  <= base_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               state_in = ST_ERASE;
            end
         end
         ST_ERASE: begin
            if (push_ok && idx_last) begin
               state_in = ST_DRAW;
            end
         end
         ST_DRAW: begin
            if (iss_done && !draw.busy) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_chan.ready = 1'b0;
      rd_addr = '0;
      push_v = 1'b0;
      push_res = draw.res;
      flush = 1'b0;
      iss_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
         end
         ST_ERASE: begin
            // read ahead so the next entry is ready when this one leaves
            rd_addr = (push_ok && !idx_last) ? idx_ff + IDX_W'(1) : idx_ff;
            push_v = 1'b1;
            push_res.loc.col = vld_q_ff ? mem_q_ff.col : DRAWN_COLUMN_RESET;
            push_res.loc.row = vld_q_ff ? mem_q_ff.row : DRAWN_ROW_RESET;
            push_res.glyph = BLANK_GLYPH;
         end
         ST_DRAW: begin
            iss_valid = !iss_done;
            push_v = draw.emit;
         end
         ST_FLUSH: begin
            flush = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // erase index, fill slot, column issue counter and x offset
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= '0;
         slot_ff <= '0;
         iss_ff  <= '0;
         x_ff    <= X_W'(X_FIRST);
      end else if (req_acc) begin
         idx_ff  <= '0;
         slot_ff <= '0;
         iss_ff  <= '0;
         x_ff    <= X_W'(X_FIRST);
      end else begin
         if (state_ff == ST_ERASE && push_ok && !idx_last) begin
            idx_ff <= idx_ff + IDX_W'(1);
         end
         if (mem_wr) begin
            slot_ff <= slot_ff + IDX_W'(1);
         end
         if (iss_valid && push_ok) begin
            iss_ff <= iss_ff + CNT_W'(1);
            x_ff   <= x_ff + X_W'(12);
         end
      end
   end

   osdah_hit_calc #(
      .NUM_COLUMNS (NUM_COLUMNS),
      .NUM_ROWS    (NUM_ROWS)
   ) u_hit_calc (
      .clock      (clock),
      .reset      (reset),
      .en         (push_ok),
      .in_valid   (iss_valid),
      .in_idx     (iss_ff[IDX_W-1:0]),
      .in_x       (x_ff),
      .tr         (tr_ff),
      .base       (base_ff),
      .origin_col (origin_col_ff),
      .origin_row (origin_row_ff),
      .draw       (draw)
   );

   // Drawn cells fill from slot 0 upward; read data is used only during the erase
   // pass and writes happen only while drawing, so the two never meet.
   assign mem_wr = (state_ff == ST_DRAW) && draw.emit && push_ok;

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         drawn_mem[slot_ff] <= draw.res.loc;
      end
      mem_q_ff <= drawn_mem[rd_addr];
      vld_q_ff <= vld_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (mem_wr) begin
         vld_ff[slot_ff] <= 1'b1;
      end
   end

   // Each new write waits in the holding register until the next one arrives,
   // so the final write of a sample is known when it moves to the output.
   assign out_free = !rsp_v_ff || rsp_chan.ready;
   assign push_ok = !hold_v_ff || out_free;
   assign push = push_v && push_ok;

   always_comb begin
      hold_v_in = hold_v_ff;
      rsp_v_in = rsp_v_ff && !rsp_chan.ready;
      load_out = 1'b0;
      load_last = 1'b0;
      if (push) begin
         hold_v_in = 1'b1;
         if (hold_v_ff) begin
            rsp_v_in = 1'b1;
            load_out = 1'b1;
         end
      end else if (flush && out_free && hold_v_ff) begin
         hold_v_in = 1'b0;
         rsp_v_in = 1'b1;
         load_out = 1'b1;
         load_last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_v_ff <= 1'b0;
         rsp_v_ff  <= 1'b0;
      end else begin
         hold_v_ff <= hold_v_in;
         rsp_v_ff  <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         hold_ff <= push_res;
      end
      if (load_out) begin
         rsp_ff      <= hold_ff;
         rsp_last_ff <= load_last;
      end
   end

   assign rsp_chan.valid = rsp_v_ff;
   assign rsp_chan.cell_column = rsp_ff.loc.col;
   assign rsp_chan.cell_row = rsp_ff.loc.row;
   assign rsp_chan.glyph_code = rsp_ff.glyph;
   assign rsp_chan.last_write = rsp_last_ff;

endmodule
